// ----- design/point_record_xyz_extractor_macros.svh -----
// Assertion macros shared by the point record extractor RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef POINT_RECORD_XYZ_EXTRACTOR_MACROS_SVH
`define POINT_RECORD_XYZ_EXTRACTOR_MACROS_SVH

// Condition implies consequence in the same cycle.
`define PRX_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define PRX_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/prx_pkg.sv -----
// Shared types, type codes and helpers of the point record extractor.
// Depends on nothing.
`timescale 1ns / 1ps
package prx_pkg;

   localparam int MAX_POINT_BYTES = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam logic [31:0] NO_COLOR_BITS = 32'h7fc0_0000;
   localparam logic [3:0]  COLOR_BYTES   = 4'd4;

   localparam logic [7:0] TYPE_INT8    = 8'd1;
   localparam logic [7:0] TYPE_UINT8   = 8'd2;
   localparam logic [7:0] TYPE_INT16   = 8'd3;
   localparam logic [7:0] TYPE_UINT16  = 8'd4;
   localparam logic [7:0] TYPE_INT32   = 8'd5;
   localparam logic [7:0] TYPE_UINT32  = 8'd6;
   localparam logic [7:0] TYPE_FLOAT32 = 8'd7;
   localparam logic [7:0] TYPE_FLOAT64 = 8'd8;

   // Configuration register indexes.
   localparam logic [2:0] REG_RECORD_BYTES  = 3'd0;
   localparam logic [2:0] REG_X_OFFSET      = 3'd1;
   localparam logic [2:0] REG_Y_OFFSET      = 3'd2;
   localparam logic [2:0] REG_Z_OFFSET      = 3'd3;
   localparam logic [2:0] REG_COORD_TYPES   = 3'd4;
   localparam logic [2:0] REG_COLOR_OFFSET  = 3'd5;
   localparam logic [2:0] REG_COLOR_PRESENT = 3'd6;
   localparam logic [2:0] REG_POINT_LIMIT   = 3'd7;

   // One complete record as it travels from the front to the back.
   typedef struct packed {
      logic [63:0] x_raw;
      logic [63:0] y_raw;
      logic [63:0] z_raw;
      logic [31:0] color;
      logic [31:0] index;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [3:0] type_size(input logic [7:0] code);
      logic [3:0] size;
      case (code)
         TYPE_INT8, TYPE_UINT8:                 size = 4'd1;
         TYPE_INT16, TYPE_UINT16:               size = 4'd2;
         TYPE_INT32, TYPE_UINT32, TYPE_FLOAT32: size = 4'd4;
         TYPE_FLOAT64:                          size = 4'd8;
         default:                               size = 4'd0;
      endcase
      return size;
   endfunction

endpackage

// ----- design/prx_front.sv -----
// Front end: byte position tracking, field capture and record classification.
// Depends on prx_pkg.
`timescale 1ns / 1ps
module prx_front #(
   parameter int MaxPointBytes = prx_pkg::MAX_POINT_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   cloud_start,
   input  logic [6:0]             record_bytes,
   input  logic [6:0]             x_offset,
   input  logic [6:0]             y_offset,
   input  logic [6:0]             z_offset,
   input  logic [23:0]            coord_types,
   input  logic [6:0]             color_offset,
   input  logic                   color_present,
   input  logic [31:0]            point_limit,
   output logic                   push,
   output prx_pkg::record_type    record
);

   localparam int PW = (MaxPointBytes > 1) ? $clog2(MaxPointBytes) : 1;

   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   emitted_ff, emitted_in, emitted_cur;
   logic [63:0]   x_raw_ff, x_raw_in, y_raw_ff, y_raw_in, z_raw_ff, z_raw_in;
   logic [31:0]   color_raw_ff, color_raw_in;
   logic [31:0]   pos32, dx, dy, dz, dc;
   logic          step_ok, last, coords_ok, color_ok;

   function automatic logic fits(input logic [6:0] step, input logic [6:0] off,
                                 input logic [3:0] size);
      return (step != 7'd0) && ({1'b0, off} + {4'd0, size} <= {1'b0, step});
   endfunction

   always_comb begin
      pos32       = cloud_start ? 32'd0 : 32'(pos_ff);
      emitted_cur = cloud_start ? 32'd0 : emitted_ff;
      step_ok     = (record_bytes != 7'd0) && (32'(record_bytes) <= 32'(MaxPointBytes));
      dx = pos32 - 32'(x_offset);
      dy = pos32 - 32'(y_offset);
      dz = pos32 - 32'(z_offset);
      dc = pos32 - 32'(color_offset);
      x_raw_in     = x_raw_ff;
      y_raw_in     = y_raw_ff;
      z_raw_in     = z_raw_ff;
      color_raw_in = color_raw_ff;
      if (accept && step_ok) begin
         if (pos32 >= 32'(x_offset) && dx < 32'd8) begin
            x_raw_in[8*dx[2:0] +: 8] = data_byte;
         end
         if (pos32 >= 32'(y_offset) && dy < 32'd8) begin
            y_raw_in[8*dy[2:0] +: 8] = data_byte;
         end
         if (pos32 >= 32'(z_offset) && dz < 32'd8) begin
            z_raw_in[8*dz[2:0] +: 8] = data_byte;
         end
         if (pos32 >= 32'(color_offset) && dc < 32'(prx_pkg::COLOR_BYTES)) begin
            color_raw_in[8*dc[1:0] +: 8] = data_byte;
         end
      end
      last      = (pos32 + 32'd1) >= 32'(record_bytes);
      coords_ok = fits(record_bytes, x_offset, prx_pkg::type_size(coord_types[7:0]))
               && fits(record_bytes, y_offset, prx_pkg::type_size(coord_types[15:8]))
               && fits(record_bytes, z_offset, prx_pkg::type_size(coord_types[23:16]));
      color_ok  = color_present && fits(record_bytes, color_offset, prx_pkg::COLOR_BYTES);
      push      = accept && step_ok && last && coords_ok && (emitted_cur < point_limit);

      pos_in     = pos_ff;
      emitted_in = emitted_ff;
      if (accept) begin
         emitted_in = push ? emitted_cur + 32'd1 : emitted_cur;
         if (!step_ok || last) begin
            pos_in = '0;
         end else begin
            pos_in = PW'(pos32 + 32'd1);
         end
      end

      record.x_raw = x_raw_in;
      record.y_raw = y_raw_in;
      record.z_raw = z_raw_in;
      record.color = color_ok ? color_raw_in : prx_pkg::NO_COLOR_BITS;
      record.index = emitted_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         emitted_ff   <= '0;
         x_raw_ff     <= '0;
         y_raw_ff     <= '0;
         z_raw_ff     <= '0;
         color_raw_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         emitted_ff   <= emitted_in;
         x_raw_ff     <= x_raw_in;
         y_raw_ff     <= y_raw_in;
         z_raw_ff     <= z_raw_in;
         color_raw_ff <= color_raw_in;
      end
   end

endmodule

// ----- design/prx_fifo.sv -----
// Short record queue between the front and back ends.
// Depends on prx_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "point_record_xyz_extractor_macros.svh"
module prx_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  prx_pkg::record_type         push_data,
   input  logic                        pop,
   output prx_pkg::record_type         head,
   output prx_pkg::queue_status_type   status
);

   localparam int Depth = prx_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(Depth);

   prx_pkg::record_type entry_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
      status.full  = (count_ff == (AW+1)'(Depth));
      status.empty = (count_ff == '0);
      head = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PRX_ASSERT_NOW(a_no_push_full, clock, reset, push, !status.full)
   `PRX_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !status.empty)
   `PRX_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !status.empty)

endmodule

// ----- design/prx_back.sv -----
// Back end: widens integers to double form, rounds doubles to float32, passes
// float32 through and holds the result register. Depends on prx_pkg.
`timescale 1ns / 1ps
module prx_back (
   input  logic                        clock,
   input  logic                        reset,
   input  prx_pkg::record_type         head,
   input  prx_pkg::queue_status_type   status,
   input  logic [23:0]                 coord_types,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [31:0]                 rsp_x_bits,
   output logic [31:0]                 rsp_y_bits,
   output logic [31:0]                 rsp_z_bits,
   output logic [31:0]                 rsp_color_bits,
   output logic [31:0]                 rsp_point_index
);

   // Bit 64 marks a float32 already in its final form in bits 31:0.
   function automatic logic [64:0] widen(input logic [63:0] raw, input logic [7:0] t);
      logic signed [32:0] v;
      logic        [31:0] mag, norm;
      logic        [4:0]  msb;
      logic        [31:0] w;
      logic        [64:0] res;
      v   = '0;
      res = '0;
      w   = raw[31:0];
      case (t)
         prx_pkg::TYPE_INT8:   v = 33'(signed'(raw[7:0]));
         prx_pkg::TYPE_UINT8:  v = {25'd0, raw[7:0]};
         prx_pkg::TYPE_INT16:  v = 33'(signed'(raw[15:0]));
         prx_pkg::TYPE_UINT16: v = {17'd0, raw[15:0]};
         prx_pkg::TYPE_INT32:  v = 33'(signed'(raw[31:0]));
         prx_pkg::TYPE_UINT32: v = {1'b0, raw[31:0]};
         default:              v = '0;
      endcase
      mag = v[32] ? 32'(-v) : v[31:0];
      msb = '0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) msb = 5'(i);
      end
      norm = mag << (5'd31 - msb);
      case (t)
         prx_pkg::TYPE_FLOAT32: begin
            if (w[30:23] == 8'hff && w[22:0] != '0) w[22] = 1'b1;
            res = {1'b1, 32'd0, w};
         end
         prx_pkg::TYPE_FLOAT64: res = {1'b0, raw};
         default: begin
            if (mag != '0) begin
               res = {1'b0, v[32], 11'(11'd1023 + 11'(msb)), norm[30:0], 21'd0};
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [31:0] narrow(input logic [63:0] b);
      logic        sign, normal, inc;
      logic [10:0] ex;
      logic [51:0] man;
      logic [52:0] m, keep;
      logic [5:0]  shamt;
      logic [107:0] wide;
      logic [30:0] base;
      logic [31:0] res;
      sign   = b[63];
      ex     = b[62:52];
      man    = b[51:0];
      m      = {1'b1, man};
      normal = (ex >= 11'd897);
      shamt  = normal ? 6'd29 : 6'(11'd926 - ex);
      wide   = {m, 55'd0} >> shamt;
      keep   = wide[107:55];
      inc    = wide[54] && ((|wide[53:0]) || keep[0]);
      base   = normal ? {8'(ex - 11'd896), keep[22:0]} : {8'd0, keep[22:0]};
      if (ex == 11'h7ff) begin
         res = (man == '0) ? {sign, 31'h7f80_0000} : {sign, 8'hff, 1'b1, man[50:29]};
      end else if (ex == 11'd0 || ex <= 11'd871) begin
         res = {sign, 31'd0};
      end else if (ex >= 11'd1151) begin
         res = {sign, 31'h7f80_0000};
      end else begin
         res = {sign, base + 31'(inc)};
      end
      return res;
   endfunction

   function automatic logic [31:0] finish(input logic [64:0] a);
      return a[64] ? a[31:0] : narrow(a[63:0]);
   endfunction

   logic        a_valid_ff, a_valid_in;
   logic [64:0] a_x_ff, a_y_ff, a_z_ff;
   logic [31:0] a_color_ff, a_index_ff;
   logic        out_en, a_en;

   always_comb begin
      out_en     = !rsp_valid || !rsp_stall;
      a_en       = !a_valid_ff || out_en;
      pop        = a_en && !status.empty;
      a_valid_in = a_en ? !status.empty : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (out_en) rsp_valid <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_x_ff     <= widen(head.x_raw, coord_types[7:0]);
         a_y_ff     <= widen(head.y_raw, coord_types[15:8]);
         a_z_ff     <= widen(head.z_raw, coord_types[23:16]);
         a_color_ff <= head.color;
         a_index_ff <= head.index;
      end
      if (out_en && a_valid_ff) begin
         rsp_x_bits      <= finish(a_x_ff);
         rsp_y_bits      <= finish(a_y_ff);
         rsp_z_bits      <= finish(a_z_ff);
         rsp_color_bits  <= a_color_ff;
         rsp_point_index <= a_index_ff;
      end
   end

endmodule

// ----- design/point_record_xyz_extractor.sv -----
// Top level of the point record extractor: configuration registers and the
// front end, record queue and back end. Depends on prx_pkg and its modules.
//
// Usage. The request channel carries one byte of a point-cloud data buffer
// per transfer (req_data_byte), with req_cloud_start high on the first byte
// of a new cloud. Records are a configured number of bytes long; multi-byte
// fields are little-endian. On the last byte of each complete record whose
// coordinate fields fit, and while fewer than point_limit records of the
// cloud were queued, one response transfer carries x, y and z as float32
// patterns, the colour bytes (or the quiet NaN pattern when colour is off
// or its field does not fit) and the index. Throughput: one byte per cycle,
// sustained while the queue is not full. The last byte of a record reaches
// rsp_valid through the record queue, the widening and the rounding stage.
// When the receiver stalls, the output register holds its transfer; records
// pile up in the four-entry queue and req_stall rises only when it is full.
// Reset (synchronous, active high) clears all registers but the queue entries
// and data registers. Configuration uses csr_write_en, csr_index and
// csr_wdata; the user must write it only while the block is idle (not enforced).
`timescale 1ns / 1ps
module point_record_xyz_extractor #(
   parameter int MaxPointBytes = prx_pkg::MAX_POINT_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_cloud_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_x_bits,
   output logic [31:0] rsp_y_bits,
   output logic [31:0] rsp_z_bits,
   output logic [31:0] rsp_color_bits,
   output logic [31:0] rsp_point_index,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [6:0]  record_bytes_ff, x_offset_ff, y_offset_ff, z_offset_ff, color_offset_ff;
   logic [23:0] coord_types_ff;
   logic        color_present_ff;
   logic [31:0] point_limit_ff;

   logic                      accept, push, pop;
   prx_pkg::record_type       record, head;
   prx_pkg::queue_status_type status;

   // The request side is held off only while the queue is full.
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_bytes_ff  <= '0;
         x_offset_ff      <= '0;
         y_offset_ff      <= '0;
         z_offset_ff      <= '0;
         coord_types_ff   <= '0;
         color_offset_ff  <= '0;
         color_present_ff <= 1'b0;
         point_limit_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            prx_pkg::REG_RECORD_BYTES:  record_bytes_ff  <= csr_wdata[6:0];
            prx_pkg::REG_X_OFFSET:      x_offset_ff      <= csr_wdata[6:0];
            prx_pkg::REG_Y_OFFSET:      y_offset_ff      <= csr_wdata[6:0];
            prx_pkg::REG_Z_OFFSET:      z_offset_ff      <= csr_wdata[6:0];
            prx_pkg::REG_COORD_TYPES:   coord_types_ff   <= csr_wdata[23:0];
            prx_pkg::REG_COLOR_OFFSET:  color_offset_ff  <= csr_wdata[6:0];
            prx_pkg::REG_COLOR_PRESENT: color_present_ff <= csr_wdata[0];
            prx_pkg::REG_POINT_LIMIT:   point_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   prx_front #(.MaxPointBytes(MaxPointBytes)) u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .data_byte(req_data_byte), .cloud_start(req_cloud_start),
      .record_bytes(record_bytes_ff), .x_offset(x_offset_ff), .y_offset(y_offset_ff),
      .z_offset(z_offset_ff), .coord_types(coord_types_ff),
      .color_offset(color_offset_ff), .color_present(color_present_ff),
      .point_limit(point_limit_ff), .push(push), .record(record)
   );

   prx_fifo u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(record),
      .pop(pop), .head(head), .status(status)
   );

   prx_back u_back (
      .clock(clock), .reset(reset), .head(head), .status(status),
      .coord_types(coord_types_ff), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_x_bits(rsp_x_bits), .rsp_y_bits(rsp_y_bits), .rsp_z_bits(rsp_z_bits),
      .rsp_color_bits(rsp_color_bits), .rsp_point_index(rsp_point_index)
   );

endmodule

// ----- sim/point_record_xyz_extractor_checker.sv -----
// Checker for the point record extractor: predicts each point from the byte
// transfers and compares it with the response channel. Depends on prx_pkg.
`timescale 1ns / 1ps
module point_record_xyz_extractor_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_cloud_start,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_x_bits,
   input  logic [31:0] rsp_y_bits,
   input  logic [31:0] rsp_z_bits,
   input  logic [31:0] rsp_color_bits,
   input  logic [31:0] rsp_point_index,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_points,
   output int          points_seen
);

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] color;
      logic [31:0] index;
   } point_type;

   point_type   expected_points[$];
   logic [6:0]  step_reg, x_off, y_off, z_off, color_off;
   logic [23:0] types_reg;
   logic        color_on;
   logic [31:0] limit_reg;
   logic [6:0]  position;
   logic [31:0] emitted;
   logic [63:0] x_cap, y_cap, z_cap;
   logic [31:0] color_cap;

   function automatic logic [31:0] double_to_single(input logic [63:0] b);
      logic [31:0] sign;
      logic [10:0] ex;
      logic [51:0] man;
      logic [63:0] m, keep, rem, half;
      int          fe, sh;
      sign = {b[63], 31'b0};
      ex = b[62:52];
      man = b[51:0];
      if (ex == 11'h7ff) begin
         if (man == 0) return sign | 32'h7f80_0000;
         return sign | 32'h7fc0_0000 | 32'(man >> 29);
      end
      if (ex == 0) return sign;
      m = {12'b1, man};
      fe = int'(ex) - 1023 + 127;
      if (fe >= 255) return sign | 32'h7f80_0000;
      if (fe >= 1) begin
         keep = m >> 29;
         rem = m & ((64'd1 << 29) - 1);
         half = 64'd1 << 28;
         if (rem > half || (rem == half && keep[0])) keep++;
         if (keep == (64'd1 << 24)) begin
            keep >>= 1;
            fe++;
         end
         if (fe >= 255) return sign | 32'h7f80_0000;
         return sign | (32'(fe) << 23) | (32'(keep) & 32'h7f_ffff);
      end
      sh = 30 - fe;
      if (sh >= 55) return sign;
      keep = m >> sh;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep++;
      return sign | 32'(keep);
   endfunction

   function automatic logic [31:0] integer_to_single(input longint v);
      real r;
      r = v;
      return double_to_single($realtobits(r));
   endfunction

   function automatic logic [31:0] decode_coord(input logic [63:0] raw,
                                                input logic [7:0] code);
      logic [31:0] w;
      case (code)
         prx_pkg::TYPE_INT8:    return integer_to_single(longint'($signed(raw[7:0])));
         prx_pkg::TYPE_UINT8:   return integer_to_single(longint'(raw[7:0]));
         prx_pkg::TYPE_INT16:   return integer_to_single(longint'($signed(raw[15:0])));
         prx_pkg::TYPE_UINT16:  return integer_to_single(longint'(raw[15:0]));
         prx_pkg::TYPE_INT32:   return integer_to_single(longint'($signed(raw[31:0])));
         prx_pkg::TYPE_UINT32:  return integer_to_single(longint'(raw[31:0]));
         prx_pkg::TYPE_FLOAT32: begin
            w = raw[31:0];
            if (w[30:23] == 8'hff && w[22:0] != 0) w[22] = 1'b1;
            return w;
         end
         prx_pkg::TYPE_FLOAT64: return double_to_single(raw);
         default:               return 32'd0;
      endcase
   endfunction

   function automatic logic field_fits(input logic [6:0] off, input logic [3:0] size);
      return step_reg != 0 && (int'(off) + int'(size)) <= int'(step_reg);
   endfunction

   function automatic logic [63:0] capture(input logic [63:0] r, input logic [6:0] pos,
                                           input logic [6:0] off, input int span,
                                           input logic [7:0] b);
      int k;
      if (pos < off) return r;
      k = int'(pos) - int'(off);
      if (k >= span) return r;
      r[8*k +: 8] = b;
      return r;
   endfunction

   task automatic take_byte(input logic [7:0] b, input logic start);
      logic [6:0] pos;
      point_type  p;
      logic       coords_ok;
      logic       color_ok;
      logic [63:0] c;
      if (start) begin
         position = 0;
         emitted = 0;
      end
      if (step_reg == 0 || step_reg > prx_pkg::MAX_POINT_BYTES) begin
         position = 0;
         return;
      end
      pos = position;
      x_cap = capture(x_cap, pos, x_off, 8, b);
      y_cap = capture(y_cap, pos, y_off, 8, b);
      z_cap = capture(z_cap, pos, z_off, 8, b);
      c = capture({32'd0, color_cap}, pos, color_off, 4, b);
      color_cap = c[31:0];
      if (int'(pos) + 1 < int'(step_reg)) begin
         position = pos + 1;
         return;
      end
      position = 0;
      coords_ok = field_fits(x_off, prx_pkg::type_size(types_reg[7:0])) &&
                  field_fits(y_off, prx_pkg::type_size(types_reg[15:8])) &&
                  field_fits(z_off, prx_pkg::type_size(types_reg[23:16]));
      color_ok = color_on && field_fits(color_off, prx_pkg::COLOR_BYTES);
      if (!coords_ok || emitted >= limit_reg) return;
      p.x = decode_coord(x_cap, types_reg[7:0]);
      p.y = decode_coord(y_cap, types_reg[15:8]);
      p.z = decode_coord(z_cap, types_reg[23:16]);
      p.color = color_ok ? color_cap : prx_pkg::NO_COLOR_BITS;
      p.index = emitted;
      emitted++;
      expected_points.push_back(p);
   endtask

   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         step_reg <= 0; x_off <= 0; y_off <= 0; z_off <= 0; color_off <= 0;
         types_reg <= 0; color_on <= 0; limit_reg <= 0;
         position = 0; emitted = 0; x_cap = 0; y_cap = 0; z_cap = 0; color_cap = 0;
         expected_points.delete();
         fail_count <= 0;
         points_seen <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               prx_pkg::REG_RECORD_BYTES:  step_reg <= csr_wdata[6:0];
               prx_pkg::REG_X_OFFSET:      x_off <= csr_wdata[6:0];
               prx_pkg::REG_Y_OFFSET:      y_off <= csr_wdata[6:0];
               prx_pkg::REG_Z_OFFSET:      z_off <= csr_wdata[6:0];
               prx_pkg::REG_COORD_TYPES:   types_reg <= csr_wdata[23:0];
               prx_pkg::REG_COLOR_OFFSET:  color_off <= csr_wdata[6:0];
               prx_pkg::REG_COLOR_PRESENT: color_on <= csr_wdata[0];
               prx_pkg::REG_POINT_LIMIT:   limit_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) take_byte(req_data_byte, req_cloud_start);
         if (rsp_valid && !rsp_stall) begin
            points_seen <= points_seen + 1;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected point, actual %h %h %h %h %h", $time,
                        rsp_x_bits, rsp_y_bits, rsp_z_bits, rsp_color_bits,
                        rsp_point_index);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_points.pop_front();
               if ({rsp_x_bits, rsp_y_bits, rsp_z_bits, rsp_color_bits,
                    rsp_point_index} !== e) begin
                  $display("%0t: point mismatch, expected %h %h %h %h %h", $time,
                           e.x, e.y, e.z, e.color, e.index);
                  $display("%0t:                 actual   %h %h %h %h %h", $time,
                           rsp_x_bits, rsp_y_bits, rsp_z_bits, rsp_color_bits,
                           rsp_point_index);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_points <= expected_points.size();
   end
endmodule

// ----- sim/point_record_xyz_extractor_tb.sv -----
// Top of the point record extractor testbench: clock, reset, configuration,
// byte stimulus and verdict. Depends on prx_pkg, the block and the checker.
`timescale 1ns / 1ps
module point_record_xyz_extractor_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_cloud_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_x_bits, rsp_y_bits, rsp_z_bits, rsp_color_bits, rsp_point_index;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = prx_pkg::REG_RECORD_BYTES;
   logic [31:0] csr_wdata = 32'd0;
   int          fail_count, pending_points, points_seen;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   int          bytes_sent = 0;

   always #5 clock = ~clock;

   point_record_xyz_extractor dut (.*);
   point_record_xyz_extractor_checker checker_inst (.*);

   // The receiver stalls at random; a new choice is made at every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // The request channel is idle while a register is written.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      req_valid <= 1'b0;
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Sends one byte as a single transfer. The sender may first idle, and valid
   // is then held until the transfer is accepted. Valid is only lowered when the
   // next byte is not already due, so it never drops and rises in the same step.
   task automatic send_byte(input logic [7:0] b, input logic start);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_cloud_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Waits until every predicted point has left, then lets the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_points != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_record(input int step, input logic start, input logic random_fill,
                              input logic [63:0] x, input logic [63:0] y,
                              input logic [63:0] z, input logic [31:0] col,
                              input int xo, input int yo, input int zo, input int co);
      logic [7:0] b;
      for (int i = 0; i < step; i++) begin
         b = random_fill ? 8'($urandom) : 8'd0;
         if (i >= xo && i < xo + 8) b = x[8*(i-xo) +: 8];
         if (i >= yo && i < yo + 8) b = y[8*(i-yo) +: 8];
         if (i >= zo && i < zo + 8) b = z[8*(i-zo) +: 8];
         if (i >= co && i < co + 4) b = col[8*(i-co) +: 8];
         send_byte(b, start && i == 0);
      end
   endtask

   // Chooses a random layout and writes all registers. Small records dominate
   // so that many points come out; some use the largest legal step or an illegal one.
   task automatic random_layout(output int step, output int xo, output int yo,
                                output int zo, output int co);
      logic [7:0] tx, ty, tz;
      tx = 8'($urandom_range(9));
      ty = 8'($urandom_range(9));
      tz = 8'($urandom_range(9));
      step = ($urandom_range(9) == 0) ? 64 : $urandom_range(24, 1);
      if ($urandom_range(19) == 0) step = $urandom_range(1) ? 0 : 65 + $urandom_range(62);
      xo = $urandom_range(step);
      yo = $urandom_range(step);
      zo = $urandom_range(step);
      co = $urandom_range(step);
      // Mostly layouts whose fields fit, so that points actually come out.
      if ($urandom_range(9) != 0 && step > 0 && step <= 64) begin
         if (xo + prx_pkg::type_size(tx) > step) xo = 0;
         if (yo + prx_pkg::type_size(ty) > step) yo = 0;
         if (zo + prx_pkg::type_size(tz) > step) zo = 0;
         if (xo + prx_pkg::type_size(tx) > step) tx = prx_pkg::TYPE_UINT8;
         if (yo + prx_pkg::type_size(ty) > step) ty = prx_pkg::TYPE_UINT8;
         if (zo + prx_pkg::type_size(tz) > step) tz = prx_pkg::TYPE_INT8;
      end
      write_reg(prx_pkg::REG_RECORD_BYTES, 32'(step));
      write_reg(prx_pkg::REG_X_OFFSET, 32'(xo));
      write_reg(prx_pkg::REG_Y_OFFSET, 32'(yo));
      write_reg(prx_pkg::REG_Z_OFFSET, 32'(zo));
      write_reg(prx_pkg::REG_COORD_TYPES, {8'd0, tz, ty, tx});
      write_reg(prx_pkg::REG_COLOR_OFFSET, 32'(co));
      write_reg(prx_pkg::REG_COLOR_PRESENT, 32'($urandom_range(1)));
      write_reg(prx_pkg::REG_POINT_LIMIT, ($urandom_range(7) == 0) ? 32'($urandom_range(3))
                                 : (($urandom_range(1)) ? 32'hffff_ffff : 32'd1000));
   endtask

   function automatic logic [63:0] random_value();
      case ($urandom_range(5))
         0: return 64'h7ff0_0000_0000_0000 | 64'($urandom);
         1: return {$urandom, $urandom} & 64'h800f_ffff_ffff_ffff;
         2: return {$urandom_range(1) ? 32'hffff_ffff : 32'd0, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int step, xo, yo, zo, co;
      int phase_bytes;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: one layout with x float64, y float32, z int16, colour.
      write_reg(prx_pkg::REG_RECORD_BYTES, 32'd24);
      write_reg(prx_pkg::REG_X_OFFSET, 32'd0);
      write_reg(prx_pkg::REG_Y_OFFSET, 32'd8);
      write_reg(prx_pkg::REG_Z_OFFSET, 32'd12);
      write_reg(prx_pkg::REG_COORD_TYPES,
                {8'd0, prx_pkg::TYPE_INT16, prx_pkg::TYPE_FLOAT32, prx_pkg::TYPE_FLOAT64});
      write_reg(prx_pkg::REG_COLOR_OFFSET, 32'd16);
      write_reg(prx_pkg::REG_COLOR_PRESENT, 32'd1);
      write_reg(prx_pkg::REG_POINT_LIMIT, 32'hffff_ffff);
      // Infinity, float NaN, the most negative int16 and an all-ones colour.
      send_record(24, 1'b1, 1'b0, 64'h7ff0_0000_0000_0000, 64'h7f80_0001,
                  64'h8000, 32'hffff_ffff, 0, 8, 12, 16);
      // Double NaN, the smallest float32 subnormal, the largest int16 and a tiny double.
      send_record(24, 1'b0, 1'b1, 64'hfff8_0000_2000_0000, 64'h0000_0001,
                  64'h7fff, 32'h0000_0000, 0, 8, 12, 16);
      send_record(24, 1'b0, 1'b1, 64'h3690_0000_0000_0001, 64'hffff_ffff,
                  64'h0000, 32'h1234_5678, 0, 8, 12, 16);
      // A trailing partial record is dropped when the next cloud starts.
      for (int i = 0; i < 5; i++) send_byte(8'hff, 1'b0);
      send_record(24, 1'b1, 1'b1, 64'h47ef_ffff_f000_0000, 64'h0, 64'h1,
                  32'h0, 0, 8, 12, 16);
      settle();

      // The other integer types, a colour field that does not fit and a limit of one.
      write_reg(prx_pkg::REG_RECORD_BYTES, 32'd8);
      write_reg(prx_pkg::REG_COORD_TYPES,
                {8'd0, prx_pkg::TYPE_UINT32, prx_pkg::TYPE_INT8, prx_pkg::TYPE_UINT8});
      write_reg(prx_pkg::REG_X_OFFSET, 32'd0);
      write_reg(prx_pkg::REG_Y_OFFSET, 32'd1);
      write_reg(prx_pkg::REG_Z_OFFSET, 32'd4);
      write_reg(prx_pkg::REG_COLOR_OFFSET, 32'd6);
      write_reg(prx_pkg::REG_POINT_LIMIT, 32'd1);
      send_record(8, 1'b1, 1'b1, 64'hff, 64'h80, 64'hffff_ffff, 32'h0, 0, 1, 4, 64);
      send_record(8, 1'b0, 1'b1, 64'h00, 64'h7f, 64'h0, 32'h0, 0, 1, 4, 64);
      settle();
      write_reg(prx_pkg::REG_COORD_TYPES,
                {8'd0, prx_pkg::TYPE_INT32, prx_pkg::TYPE_UINT16, 8'd9});
      write_reg(prx_pkg::REG_POINT_LIMIT, 32'd0);
      send_record(8, 1'b1, 1'b1, 64'h0, 64'hffff, 64'h8000_0000, 32'h0, 0, 1, 4, 64);
      write_reg(prx_pkg::REG_POINT_LIMIT, 32'd5);
      send_record(8, 1'b1, 1'b1, 64'h0, 64'hffff, 64'h8000_0001, 32'h0, 0, 1, 4, 64);
      settle();
      // A coordinate that does not fit: no point.
      write_reg(prx_pkg::REG_Z_OFFSET, 32'd64);
      send_record(8, 1'b0, 1'b1, 64'h0, 64'h0, 64'h0, 32'h0, 0, 1, 64, 64);
      // A step of zero disables output.
      write_reg(prx_pkg::REG_RECORD_BYTES, 32'd0);
      for (int i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);
      settle();

      // Random part in three idling phases of at least 150 bytes each.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 75 : 0;
         receiver_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 13 : 0;
         phase_bytes = 0;
         while (phase_bytes < 150) begin
            random_layout(step, xo, yo, zo, co);
            for (int r = 0; r < $urandom_range(5, 1); r++) begin
               if ($urandom_range(7) == 0) begin
                  send_byte(8'($urandom), $urandom_range(1)); // stray noise byte
                  phase_bytes++;
               end
               send_record((step > 64) ? 3 : step, r == 0, 1'b1, random_value(),
                           random_value(), random_value(), $urandom, xo, yo, zo, co);
               phase_bytes += (step > 64) ? 3 : step;
            end
            settle();
         end
      end

      $display("Sent %0d bytes through %0s layouts; %0d points checked.", bytes_sent,
               "random and directed", points_seen);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+design
design/prx_pkg.sv
design/prx_front.sv
design/prx_fifo.sv
design/prx_back.sv
design/point_record_xyz_extractor.sv
sim/point_record_xyz_extractor_checker.sv
sim/point_record_xyz_extractor_tb.sv
